/* src/ascm_pkg.sv */
`default_nettype none
package ascm_pkg;

   localparam int MAX_DIMENSION = 4096;
   localparam int DIM_W  = 13;
   localparam int CRD_W  = 16;
   localparam int PROD_W = 2 * DIM_W;
   localparam int B_W    = PROD_W + 1;
   localparam int NUM_W  = 32;
   localparam int MAG_W  = NUM_W;
   localparam int DEN_W  = DIM_W + 1;
   localparam int QUO_W  = CRD_W;
   localparam int STEPS_PER_STAGE = 2;
   localparam int DIV_STAGES = QUO_W / STEPS_PER_STAGE;
   localparam int CSR_IDX_W = 3;
   localparam int MODE_W = 3;

   localparam logic [CSR_IDX_W-1:0] CSR_SCALE_MODE    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SOURCE_WIDTH  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SOURCE_HEIGHT = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_VIEW_WIDTH    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_VIEW_HEIGHT   = 3'd4;

   localparam logic [MODE_W-1:0] MODE_STRETCH = 3'd0;
   localparam logic [MODE_W-1:0] MODE_PIXEL   = 3'd1;
   localparam logic [MODE_W-1:0] MODE_FIT     = 3'd2;
   localparam logic [MODE_W-1:0] MODE_FILL    = 3'd3;
   localparam logic [MODE_W-1:0] MODE_HEIGHT  = 3'd4;
   localparam logic [MODE_W-1:0] MODE_WIDTH   = 3'd5;

   typedef struct packed {
      logic signed [CRD_W-1:0] pointer_x;
      logic signed [CRD_W-1:0] pointer_y;
   } req_type;

   typedef struct packed {
      logic signed [CRD_W-1:0] mapped_x;
      logic signed [CRD_W-1:0] mapped_y;
   } rsp_type;

   typedef enum logic [1:0] {
      SEL_IDENT,
      SEL_PIXEL,
      SEL_RATIO
   } axis_sel_type;

   typedef struct packed {
      logic             neg;
      logic             ovf;
      logic [DEN_W-1:0] den;
      logic [MAG_W-1:0] mag;
   } div_req_type;

   typedef struct packed {
      logic             neg;
      logic             ovf;
      logic [DEN_W-1:0] den;
      logic [MAG_W-1:0] rem;
      logic [QUO_W-1:0] quo;
   } div_stage_type;

endpackage
`default_nettype wire

/* src/ascm_div.sv */
`default_nettype none
module ascm_div (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                in_valid,
   input  wire ascm_pkg::div_req_type in_req,
   output logic                     out_valid,
   output logic signed [ascm_pkg::CRD_W-1:0] out_value
);

   localparam int NS = ascm_pkg::DIV_STAGES;
   localparam int SP = ascm_pkg::STEPS_PER_STAGE;
   localparam int QW = ascm_pkg::QUO_W;
   localparam int MW = ascm_pkg::MAG_W;
   localparam logic [QW-1:0] POS_MAX = {1'b0, {(QW-1){1'b1}}};
   localparam logic [QW-1:0] NEG_MAX = {1'b1, {(QW-1){1'b0}}};

   ascm_pkg::div_stage_type cur [NS+1];
   ascm_pkg::div_stage_type stage_ff [NS];
   ascm_pkg::div_stage_type stage_in [NS];
   logic                    vld_ff [NS];
   logic                    out_valid_ff;
   logic [QW-1:0]           out_value_ff;
   logic [QW-1:0]           out_value_in;

   assign cur[0] = '{neg: in_req.neg, ovf: in_req.ovf, den: in_req.den,
                     rem: in_req.mag, quo: '0};

   for (genvar k = 0; k < NS; k++) begin : g_stage
      always_comb begin
         logic [MW-1:0] sh;
         logic [MW:0]   diff;
         stage_in[k] = cur[k];
         for (int j = 0; j < SP; j++) begin
            sh   = MW'(stage_in[k].den) << (QW - 1 - SP * k - j);
            diff = {1'b0, stage_in[k].rem} - {1'b0, sh};
            if (!diff[MW]) begin
               stage_in[k].rem = diff[MW-1:0];
               stage_in[k].quo[QW-1-SP*k-j] = 1'b1;
            end
         end
      end

      always_ff @(posedge clock) begin
         stage_ff[k] <= stage_in[k];
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else if (k == 0) begin
            vld_ff[k] <= in_valid;
         end else begin
            vld_ff[k] <= vld_ff[(k == 0) ? 0 : k-1];
         end
      end

      assign cur[k+1] = stage_ff[k];
   end

   always_comb begin
      if (cur[NS].ovf) begin
         out_value_in = cur[NS].neg ? NEG_MAX : POS_MAX;
      end else if (cur[NS].neg) begin
         out_value_in = (cur[NS].quo > NEG_MAX) ? NEG_MAX : QW'(-cur[NS].quo);
      end else begin
         out_value_in = (cur[NS].quo > POS_MAX) ? POS_MAX : cur[NS].quo;
      end
   end

   always_ff @(posedge clock) begin
      out_value_ff <= out_value_in;
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= vld_ff[NS-1];
      end
   end

   assign out_valid = out_valid_ff;
   assign out_value = $signed(out_value_ff);

endmodule
`default_nettype wire

/* src/aspect_scale_coordinate_mapper_core.sv */
// channel | direction | handshake               | payload
// req     | in        | start high, busy low    | req_data (pointer_x, pointer_y)
// rsp     | out       | rsp_strobe, one cycle   | rsp_data (mapped_x, mapped_y)
// csr     | in        | csr_valid and csr_ready | csr_index, csr_data
// one item per cycle outside reset; each result passes through the registered core and divider stages
// the divider is a 16-bit restoring divider, two quotient bits per stage
// busy is high only while reset is asserted; csr_ready is always high
// synchronous reset clears the pipeline valid bits and the configuration registers
// results cannot be held off, so nothing in the pipeline ever stalls
`default_nettype none
module aspect_scale_coordinate_mapper_core (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 start,
   output logic                                      busy,
   input  wire ascm_pkg::req_type                    req_data,
   output logic                                      rsp_strobe,
   output ascm_pkg::rsp_type                         rsp_data,
   input  wire logic                                 csr_valid,
   output logic                                      csr_ready,
   input  wire logic [ascm_pkg::CSR_IDX_W-1:0]       csr_index,
   input  wire logic [ascm_pkg::DIM_W-1:0]           csr_data
);

   localparam int DW = ascm_pkg::DIM_W;
   localparam int CW = ascm_pkg::CRD_W;
   localparam int PW = ascm_pkg::PROD_W;
   localparam int BW = ascm_pkg::B_W;
   localparam int NW = ascm_pkg::NUM_W;
   localparam int MW = ascm_pkg::MAG_W;
   localparam int EW = ascm_pkg::DEN_W;
   localparam int QW = ascm_pkg::QUO_W;

   function automatic logic [DW-1:0] eff_dim(input logic [DW-1:0] v);
      if (v == '0) begin
         return DW'(1);
      end else if (32'(v) > ascm_pkg::MAX_DIMENSION) begin
         return DW'(ascm_pkg::MAX_DIMENSION);
      end else begin
         return v;
      end
   endfunction

   logic [ascm_pkg::MODE_W-1:0] mode_ff;
   logic [DW-1:0] src_w_ff, src_h_ff, view_w_ff, view_h_ff;
   logic          accept;

   assign busy      = reset;
   assign csr_ready = 1'b1;
   assign accept    = start && !busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= ascm_pkg::MODE_FIT;
         src_w_ff  <= DW'(1);
         src_h_ff  <= DW'(1);
         view_w_ff <= DW'(1);
         view_h_ff <= DW'(1);
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            ascm_pkg::CSR_SCALE_MODE: begin
               mode_ff <= csr_data[ascm_pkg::MODE_W-1:0];
            end
            ascm_pkg::CSR_SOURCE_WIDTH:  src_w_ff  <= eff_dim(csr_data);
            ascm_pkg::CSR_SOURCE_HEIGHT: src_h_ff  <= eff_dim(csr_data);
            ascm_pkg::CSR_VIEW_WIDTH:    view_w_ff <= eff_dim(csr_data);
            ascm_pkg::CSR_VIEW_HEIGHT:   view_h_ff <= eff_dim(csr_data);
            default: ;
         endcase
      end
   end

   // stage 1: cross products
   logic                 v1_ff;
   logic signed [CW-1:0] cx1_ff, cy1_ff;
   logic [PW-1:0]        wiho_ff, hiwo_ff;

   always_ff @(posedge clock) begin
      cx1_ff  <= req_data.pointer_x;
      cy1_ff  <= req_data.pointer_y;
      wiho_ff <= src_w_ff * view_h_ff;
      hiwo_ff <= src_h_ff * view_w_ff;
      if (reset) begin
         v1_ff <= 1'b0;
      end else begin
         v1_ff <= accept;
      end
   end

   // stage 2: per-axis coefficients
   logic signed [BW-1:0] cross_diff;
   logic                 narrow;
   ascm_pkg::axis_sel_type sel_x, sel_y;
   logic [DW-1:0]        ax_in, ay_in, dx_in, dy_in;
   logic signed [BW-1:0] bx_in, by_in;

   assign cross_diff = $signed({1'b0, wiho_ff}) - $signed({1'b0, hiwo_ff});
   assign narrow     = cross_diff > 0;

   always_comb begin
      sel_x = ascm_pkg::SEL_IDENT;
      sel_y = ascm_pkg::SEL_IDENT;
      unique case (mode_ff)
         ascm_pkg::MODE_PIXEL: begin
            sel_x = ascm_pkg::SEL_PIXEL;
            sel_y = ascm_pkg::SEL_PIXEL;
         end
         ascm_pkg::MODE_FIT: begin
            if (narrow) sel_y = ascm_pkg::SEL_RATIO;
            else        sel_x = ascm_pkg::SEL_RATIO;
         end
         ascm_pkg::MODE_FILL: begin
            if (narrow) sel_x = ascm_pkg::SEL_RATIO;
            else        sel_y = ascm_pkg::SEL_RATIO;
         end
         ascm_pkg::MODE_HEIGHT: sel_x = ascm_pkg::SEL_RATIO;
         ascm_pkg::MODE_WIDTH:  sel_y = ascm_pkg::SEL_RATIO;
         default: ;
      endcase
   end

   always_comb begin
      unique case (sel_x)
         ascm_pkg::SEL_PIXEL: begin
            ax_in = DW'(1);
            bx_in = BW'($signed({1'b0, src_w_ff})) - BW'($signed({1'b0, view_w_ff}));
            dx_in = DW'(1);
         end
         ascm_pkg::SEL_RATIO: begin
            ax_in = src_h_ff;
            bx_in = cross_diff;
            dx_in = view_h_ff;
         end
         default: begin
            ax_in = src_w_ff;
            bx_in = '0;
            dx_in = view_w_ff;
         end
      endcase
      unique case (sel_y)
         ascm_pkg::SEL_PIXEL: begin
            ay_in = DW'(1);
            by_in = BW'($signed({1'b0, src_h_ff})) - BW'($signed({1'b0, view_h_ff}));
            dy_in = DW'(1);
         end
         ascm_pkg::SEL_RATIO: begin
            ay_in = src_w_ff;
            by_in = -cross_diff;
            dy_in = view_w_ff;
         end
         default: begin
            ay_in = src_h_ff;
            by_in = '0;
            dy_in = view_h_ff;
         end
      endcase
   end

   logic                 v2_ff;
   logic signed [CW-1:0] cx2_ff, cy2_ff;
   logic [DW-1:0]        ax_ff, ay_ff, dx_ff, dy_ff;
   logic signed [BW-1:0] bx_ff, by_ff;

   always_ff @(posedge clock) begin
      cx2_ff <= cx1_ff;
      cy2_ff <= cy1_ff;
      ax_ff  <= ax_in;
      ay_ff  <= ay_in;
      bx_ff  <= bx_in;
      by_ff  <= by_in;
      dx_ff  <= dx_in;
      dy_ff  <= dy_in;
      if (reset) begin
         v2_ff <= 1'b0;
      end else begin
         v2_ff <= v1_ff;
      end
   end

   // stage 3: numerator 2*a*c + b
   logic                 v3_ff;
   logic signed [NW-1:0] nx_ff, ny_ff, nx_in, ny_in;
   logic [EW-1:0]        ex3_ff, ey3_ff;

   assign nx_in = ((NW'(cx2_ff) * NW'($signed({1'b0, ax_ff}))) <<< 1) + NW'(bx_ff);
   assign ny_in = ((NW'(cy2_ff) * NW'($signed({1'b0, ay_ff}))) <<< 1) + NW'(by_ff);

   always_ff @(posedge clock) begin
      nx_ff  <= nx_in;
      ny_ff  <= ny_in;
      ex3_ff <= {dx_ff, 1'b0};
      ey3_ff <= {dy_ff, 1'b0};
      if (reset) begin
         v3_ff <= 1'b0;
      end else begin
         v3_ff <= v2_ff;
      end
   end

   // stage 4: magnitude and range check
   logic                  v4_ff;
   ascm_pkg::div_req_type dvx_ff, dvy_ff, dvx_in, dvy_in;

   always_comb begin
      dvx_in.neg = nx_ff[NW-1];
      dvx_in.den = ex3_ff;
      dvx_in.mag = dvx_in.neg ? MW'(-nx_ff) : MW'(nx_ff);
      dvx_in.ovf = dvx_in.mag >= (MW'(ex3_ff) << QW);
      dvy_in.neg = ny_ff[NW-1];
      dvy_in.den = ey3_ff;
      dvy_in.mag = dvy_in.neg ? MW'(-ny_ff) : MW'(ny_ff);
      dvy_in.ovf = dvy_in.mag >= (MW'(ey3_ff) << QW);
   end

   always_ff @(posedge clock) begin
      dvx_ff <= dvx_in;
      dvy_ff <= dvy_in;
      if (reset) begin
         v4_ff <= 1'b0;
      end else begin
         v4_ff <= v3_ff;
      end
   end

   logic                 out_vx, out_vy;
   logic signed [CW-1:0] mx, my;

   ascm_div u_div_x (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (v4_ff),
      .in_req    (dvx_ff),
      .out_valid (out_vx),
      .out_value (mx)
   );

   ascm_div u_div_y (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (v4_ff),
      .in_req    (dvy_ff),
      .out_valid (out_vy),
      .out_value (my)
   );

   assign rsp_strobe        = out_vx && out_vy;
   assign rsp_data.mapped_x = mx;
   assign rsp_data.mapped_y = my;

endmodule
`default_nettype wire

/* src/ascm_checker.sv */
`default_nettype none
module ascm_checker (
   input wire logic                           clock,
   input wire logic                           reset,
   input wire logic                           start,
   input wire logic                           busy,
   input wire ascm_pkg::req_type              req_data,
   input wire logic                           rsp_strobe,
   input wire ascm_pkg::rsp_type              rsp_data,
   input wire logic                           csr_valid,
   input wire logic                           csr_ready
);

   localparam int LATENCY = 13;

   logic xfer;
   assign xfer = start && !busy;

   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(xfer, LATENCY))
      else $error("result without a matching request transfer");

   a_no_loss: assert property (@(posedge clock) disable iff (reset)
      xfer |-> ##13 rsp_strobe)
      else $error("request transfer produced no result");

   a_same_in_same_out: assert property (@(posedge clock) disable iff (reset)
      (xfer && $past(xfer) && req_data == $past(req_data)
       && !(csr_valid && csr_ready) && !$past(csr_valid && csr_ready))
      |-> ##13 (rsp_data == $past(rsp_data)))
      else $error("identical requests gave different results");

endmodule

bind aspect_scale_coordinate_mapper_core ascm_checker u_ascm_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .req_data   (req_data),
   .rsp_strobe (rsp_strobe),
   .rsp_data   (rsp_data),
   .csr_valid  (csr_valid),
   .csr_ready  (csr_ready)
);
`default_nettype wire

/* tb/aspect_scale_coordinate_mapper_core_tb.sv */
`timescale 1ns / 100ps
`default_nettype none
module aspect_scale_coordinate_mapper_core_tb;

   localparam int MAX_DIM = ascm_pkg::MAX_DIMENSION;
   localparam int SETTLE_CYCLES = 24;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam logic [ascm_pkg::CSR_IDX_W-1:0] CSR_UNUSED_LO = 3'd5;
   localparam logic [ascm_pkg::CSR_IDX_W-1:0] CSR_UNUSED_HI = 3'd7;
   localparam logic [ascm_pkg::MODE_W-1:0] MODE_SPARE_A = 3'd6;
   localparam logic [ascm_pkg::MODE_W-1:0] MODE_SPARE_B = 3'd7;

   logic clock;
   logic reset;
   logic start;
   logic busy;
   ascm_pkg::req_type req_data;
   logic rsp_strobe;
   ascm_pkg::rsp_type rsp_data;
   logic csr_valid;
   logic csr_ready;
   logic [ascm_pkg::CSR_IDX_W-1:0] csr_index;
   logic [ascm_pkg::DIM_W-1:0] csr_data;

   logic [ascm_pkg::MODE_W-1:0] cur_mode;
   logic [ascm_pkg::DIM_W-1:0] cur_src_w, cur_src_h, cur_view_w, cur_view_h;

   ascm_pkg::rsp_type pending_maps[$];
   int errors;
   int items_sent;
   int results_seen;
   int csr_writes;
   int idle_pct;
   int quiet_cycles;

   aspect_scale_coordinate_mapper_core uut (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req_data(req_data),
      .rsp_strobe(rsp_strobe), .rsp_data(rsp_data), .csr_valid(csr_valid),
      .csr_ready(csr_ready), .csr_index(csr_index), .csr_data(csr_data)
   );

   always begin
      clock = 1'b1;
      #1;
      clock = 1'b0;
      #1;
   end

   function automatic longint clamp_dim(logic [ascm_pkg::DIM_W-1:0] v);
      if (v == 0) return 1;
      if (v > MAX_DIM) return MAX_DIM;
      return longint'(v);
   endfunction

   function automatic logic signed [ascm_pkg::CRD_W-1:0] scale_axis(longint c, longint p,
                                                                    longint q, longint src,
                                                                    longint view);
      longint num, den, r;
      num = (2 * q * c - (q - p) * view) * src;
      den = 2 * view * p;
      r = num / den;
      if (r > 32767) r = 32767;
      if (r < -32768) r = -32768;
      return r[ascm_pkg::CRD_W-1:0];
   endfunction

   function automatic ascm_pkg::rsp_type predict_mapping(ascm_pkg::req_type r);
      longint wi, hi, wo, ho, px, qx, py, qy;
      logic narrow;
      ascm_pkg::rsp_type m;
      wi = clamp_dim(cur_src_w);
      hi = clamp_dim(cur_src_h);
      wo = clamp_dim(cur_view_w);
      ho = clamp_dim(cur_view_h);
      px = 1; qx = 1; py = 1; qy = 1;
      narrow = (wo * hi) < (wi * ho);
      case (cur_mode)
         ascm_pkg::MODE_PIXEL: begin
            px = wi; qx = wo; py = hi; qy = ho;
         end
         ascm_pkg::MODE_FIT: begin
            if (narrow) begin
               py = wo * hi; qy = ho * wi;
            end else begin
               px = wi * ho; qx = hi * wo;
            end
         end
         ascm_pkg::MODE_FILL: begin
            if (narrow) begin
               px = wi * ho; qx = hi * wo;
            end else begin
               py = wo * hi; qy = ho * wi;
            end
         end
         ascm_pkg::MODE_HEIGHT: begin
            px = wi * ho; qx = hi * wo;
         end
         ascm_pkg::MODE_WIDTH: begin
            py = wo * hi; qy = ho * wi;
         end
         default: ;
      endcase
      m.mapped_x = scale_axis(longint'(r.pointer_x), px, qx, wi, wo);
      m.mapped_y = scale_axis(longint'(r.pointer_y), py, qy, hi, ho);
      return m;
   endfunction

   task automatic report_mismatch(input string msg);
      $display("mismatch at %0t: %s", $time, msg);
      errors++;
   endtask

   // results cannot be held off, so every strobe is a transfer
   always @(posedge clock) begin
      ascm_pkg::rsp_type want;
      if (!reset && rsp_strobe) begin
         results_seen++;
         if (pending_maps.size() == 0) begin
            report_mismatch($sformatf("unexpected result x=%0d y=%0d",
                                      rsp_data.mapped_x, rsp_data.mapped_y));
         end else begin
            want = pending_maps.pop_front();
            if (rsp_data.mapped_x !== want.mapped_x)
               report_mismatch($sformatf("mapped_x got %0d want %0d",
                                         rsp_data.mapped_x, want.mapped_x));
            if (rsp_data.mapped_y !== want.mapped_y)
               report_mismatch($sformatf("mapped_y got %0d want %0d",
                                         rsp_data.mapped_y, want.mapped_y));
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe || (csr_valid && csr_ready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog expired with %0d results outstanding", pending_maps.size());
         $display("FAIL");
         $finish;
      end
   end

   task automatic wait_drained();
      while (pending_maps.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [ascm_pkg::CSR_IDX_W-1:0] idx,
                            input logic [ascm_pkg::DIM_W-1:0] val);
      wait_drained();
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      csr_writes++;
      case (idx)
         ascm_pkg::CSR_SCALE_MODE:    cur_mode = val[ascm_pkg::MODE_W-1:0];
         ascm_pkg::CSR_SOURCE_WIDTH:  cur_src_w = val;
         ascm_pkg::CSR_SOURCE_HEIGHT: cur_src_h = val;
         ascm_pkg::CSR_VIEW_WIDTH:    cur_view_w = val;
         ascm_pkg::CSR_VIEW_HEIGHT:   cur_view_h = val;
         default: ;
      endcase
      csr_valid <= 1'b0;
   endtask

   task automatic set_geometry(input logic [ascm_pkg::MODE_W-1:0] mode,
                               input logic [ascm_pkg::DIM_W-1:0] sw,
                               input logic [ascm_pkg::DIM_W-1:0] sh,
                               input logic [ascm_pkg::DIM_W-1:0] vw,
                               input logic [ascm_pkg::DIM_W-1:0] vh);
      write_csr(ascm_pkg::CSR_SCALE_MODE, ascm_pkg::DIM_W'(mode));
      write_csr(ascm_pkg::CSR_SOURCE_WIDTH, sw);
      write_csr(ascm_pkg::CSR_SOURCE_HEIGHT, sh);
      write_csr(ascm_pkg::CSR_VIEW_WIDTH, vw);
      write_csr(ascm_pkg::CSR_VIEW_HEIGHT, vh);
   endtask

   task automatic send_pointer(input logic signed [ascm_pkg::CRD_W-1:0] x,
                               input logic signed [ascm_pkg::CRD_W-1:0] y);
      ascm_pkg::req_type r;
      r.pointer_x = x;
      r.pointer_y = y;
      // each idle cycle drawn on its own so the idle share matches idle_pct
      while (idle_pct > 0 && $urandom_range(99, 0) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (busy);
      pending_maps.push_back(predict_mapping(r));
      items_sent++;
   endtask

   task automatic stop_sending();
      start <= 1'b0;
      @(posedge clock);
   endtask

   task automatic send_corners();
      send_pointer(16'sh8000, 16'sh7fff);
      send_pointer(16'sh7fff, 16'sh8000);
      send_pointer(16'sd0, 16'sd0);
      send_pointer(-16'sd1, 16'sd1);
   endtask

   task automatic test_reset_defaults();
      send_corners();
      stop_sending();
   endtask

   task automatic test_directed_modes();
      logic [ascm_pkg::MODE_W-1:0] m;
      // every mode on a lopsided geometry, spare codes included
      for (int i = 0; i < 8; i++) begin
         m = ascm_pkg::MODE_W'(i);
         set_geometry(m, 13'd640, 13'd480, 13'd1920, 13'd1080);
         send_pointer(16'sd960, -16'sd37);
         stop_sending();
      end
      set_geometry(MODE_SPARE_A, 13'd1, 13'd1, 13'd1, 13'd1);
      set_geometry(MODE_SPARE_B, 13'd1, 13'd1, 13'd1, 13'd1);
      // zero sizes used as one, oversize clamped
      set_geometry(ascm_pkg::MODE_PIXEL, 13'd0, 13'h1fff, 13'd4097, 13'd0);
      send_corners();
      stop_sending();
      // largest source over smallest view drives saturation
      set_geometry(ascm_pkg::MODE_FILL, 13'd4096, 13'd4096, 13'd1, 13'd2);
      send_corners();
      send_pointer(16'sd1, 16'sd1);
      stop_sending();
      // writes to unused indexes change nothing
      write_csr(CSR_UNUSED_LO, 13'h1fff);
      write_csr(CSR_UNUSED_HI, 13'd0);
      send_corners();
      stop_sending();
   endtask

   function automatic logic [ascm_pkg::DIM_W-1:0] pick_dim();
      int k;
      k = $urandom_range(19, 0);
      if (k == 0) return 13'd0;
      if (k == 1) return ascm_pkg::DIM_W'($urandom_range(8191, 4097));
      if (k == 2) return 13'd4096;
      if (k < 10) return ascm_pkg::DIM_W'($urandom_range(64, 1));
      return ascm_pkg::DIM_W'($urandom_range(4096, 1));
   endfunction

   task automatic test_random_geometry(input int settings, input int per_setting);
      int span, pct_sel;
      logic signed [ascm_pkg::CRD_W-1:0] x, y;
      for (int s = 0; s < settings; s++) begin
         pct_sel = s % 4;
         idle_pct = (pct_sel == 1) ? 66 : (pct_sel == 3) ? 17 : 0;
         set_geometry(ascm_pkg::MODE_W'($urandom_range(7, 0)), pick_dim(), pick_dim(),
                      pick_dim(), pick_dim());
         span = int'(2 * clamp_dim(cur_view_w) + 2 * clamp_dim(cur_view_h));
         for (int i = 0; i < per_setting; i++) begin
            if ($urandom_range(3, 0) == 0) begin
               x = ascm_pkg::CRD_W'($urandom);
               y = ascm_pkg::CRD_W'($urandom);
            end else begin
               x = $signed(ascm_pkg::CRD_W'($urandom_range(2 * span, 0)))
                   - ascm_pkg::CRD_W'(span / 2);
               y = $signed(ascm_pkg::CRD_W'($urandom_range(2 * span, 0)))
                   - ascm_pkg::CRD_W'(span / 2);
            end
            send_pointer(x, y);
            // sender holds off until the pipeline has emptied
            if (i == per_setting / 2 && s % 5 == 0) begin
               start <= 1'b0;
               while (pending_maps.size() != 0) @(posedge clock);
            end
         end
         stop_sending();
      end
      idle_pct = 0;
   endtask

   initial begin
      errors = 0;
      items_sent = 0;
      results_seen = 0;
      csr_writes = 0;
      idle_pct = 0;
      quiet_cycles = 0;
      cur_mode = ascm_pkg::MODE_FIT;
      cur_src_w = 13'd1;
      cur_src_h = 13'd1;
      cur_view_w = 13'd1;
      cur_view_h = 13'd1;
      reset <= 1'b1;
      start <= 1'b0;
      req_data <= '0;
      csr_valid <= 1'b0;
      csr_index <= ascm_pkg::CSR_SCALE_MODE;
      csr_data <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_defaults();
      test_directed_modes();
      test_random_geometry(16, 50);

      wait_drained();
      $display("covered %0d pointer transfers, %0d results, %0d register writes",
               items_sent, results_seen, csr_writes);
      $display("all scale modes, clamped and zero sizes, saturation and idle gaps exercised");
      if (errors == 0) begin
         $display("PASS");
      end else begin
         $display("%0d mismatches", errors);
         $display("FAIL");
      end
      $finish;
   end

endmodule
`default_nettype wire
